>>> rtl/core/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg: shared types and constants for the UTF-8 stream decoder
// Byte and character payload widths, lead byte codes, result record type.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int LEN_W    = 3;
    localparam int MAX_RES  = 4;
    localparam int HELD_D   = 3;
    localparam int CNT_W    = 2;

    // Lead byte classes
    localparam logic [7:0] LEAD_MIN    = 8'hC0;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;

    localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4   = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  seq_length;
        logic              invalid;
        logic [BYTE_W-1:0] raw_lead;
    } char_t;

    // Sequence length announced by a byte; zero for F8-FF
    function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if (b < LEAD_MIN)
            len = LEN_1;
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
            len = LEN_2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
            len = LEN_3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
            len = LEN_4;
        else
            len = LEN_BAD;
        return len;
    endfunction

    function automatic char_t make_char(input logic [CP_W-1:0] cp,
                                        input logic [LEN_W-1:0] len,
                                        input logic inv,
                                        input logic [BYTE_W-1:0] lead);
        char_t c;
        c.code_point = cp;
        c.seq_length = len;
        c.invalid    = inv;
        c.raw_lead   = lead;
        return c;
    endfunction

endpackage

>>> rtl/core/usd_if.sv
// ----------------------------------------------------------------------------
// usd_if: stream channels of the UTF-8 stream decoder
// Byte channel into the decoder and character channel out of it.
// ----------------------------------------------------------------------------
interface usd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [usd_pkg::BYTE_W-1:0] data_byte;
    logic                       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface usd_char_if;
    logic                       valid;
    logic                       ready;
    logic [usd_pkg::CP_W-1:0]   code_point;
    logic [usd_pkg::LEN_W-1:0]  seq_length;
    logic                       invalid;
    logic [usd_pkg::BYTE_W-1:0] raw_lead;
    logic                       last_of_run;

    modport source (output valid, output code_point, output seq_length, output invalid,
                    output raw_lead, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input seq_length, input invalid,
                    input raw_lead, input last_of_run, output ready);
endinterface

>>> rtl/core/utf8_stream_decoder.sv
// Path: an accepted byte goes from the input register through decode to the result buffer
//   once that buffer holds nothing still waiting downstream or its last character leaves.
// Throughput: one byte per cycle while the character side is ready and each byte yields at
//   most one character; a byte with more (at most four) holds the buffer until all drain.
// Reset: rst_n clears the input valid flag, result count, read index and pending counts.
// ----------------------------------------------------------------------------
// utf8_stream_decoder: lax UTF-8 decoder, one byte in per transfer
// Input register, single-pass decode logic, four-entry result buffer.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    usd_byte_if.sink    text,
    usd_char_if.source  chars
);

    // ------------------------------------------------------------------
    // Input register: parts the byte side from the result side, so a new
    // byte can be taken while the previous character waits downstream.
    // ------------------------------------------------------------------
    logic                       in_valid_reg;
    logic [usd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_eot_reg;

    // Pending sequence state
    logic [usd_pkg::BYTE_W-1:0] held_reg [0:usd_pkg::HELD_D-1];
    logic [usd_pkg::CNT_W-1:0]  held_cnt_reg;
    logic [usd_pkg::LEN_W-1:0]  exp_len_reg;

    // Result buffer: every character one byte causes, drained one per cycle while chars.ready
    usd_pkg::char_t             res_reg [0:usd_pkg::MAX_RES-1];
    logic [usd_pkg::LEN_W-1:0]  left_reg;
    logic [1:0]                 rd_idx_reg;

    // Decode results
    usd_pkg::char_t             res_next [0:usd_pkg::MAX_RES-1];
    logic [usd_pkg::LEN_W-1:0]  res_cnt_next;
    logic [usd_pkg::BYTE_W-1:0] held_next [0:usd_pkg::HELD_D-1];
    logic [usd_pkg::CNT_W-1:0]  held_cnt_next;
    logic [usd_pkg::LEN_W-1:0]  exp_len_next;

    logic advance;
    logic out_fire;

    // Move the registered byte into decode once the buffer is empty, or
    // its last character is leaving this cycle.
    assign out_fire   = chars.valid && chars.ready;
    assign advance    = in_valid_reg &&
                        ((left_reg == '0) || ((left_reg == usd_pkg::LEN_1) && chars.ready));
    assign text.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.data_byte;
            in_eot_reg  <= text.end_of_text;
        end
    end

    // ------------------------------------------------------------------
    // Decode: one pass over the registered byte and the pending state.
    // Order of results: flush of a broken sequence, then the byte's own
    // result, then an end-of-text flush of whatever is left open.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [usd_pkg::BYTE_W-1:0] b;
        logic                       pending;
        logic                       is_cont;
        logic [usd_pkg::LEN_W-1:0]  len;
        logic [usd_pkg::CP_W-1:0]   cp;
        logic [usd_pkg::LEN_W-1:0]  n;

        b       = in_byte_reg;
        pending = (exp_len_reg != '0) && (held_cnt_reg != '0);
        is_cont = (b & usd_pkg::CONT_MASK) == usd_pkg::CONT_CODE;
        len     = usd_pkg::lead_len(b);
        cp      = '0;
        n       = '0;

        for (int i = 0; i < usd_pkg::MAX_RES; i++)
        begin
            res_next[i] = '0;
        end
        for (int i = 0; i < usd_pkg::HELD_D; i++)
        begin
            held_next[i] = held_reg[i];
        end
        held_cnt_next = pending ? held_cnt_reg : '0;
        exp_len_next  = pending ? exp_len_reg : '0;

        // Broken sequence: invalid lead, then held continuations as singles
        if (pending && !is_cont)
        begin
            res_next[n[1:0]] = usd_pkg::make_char('0, usd_pkg::LEN_BAD, 1'b1, held_next[0]);
            n = n + 3'd1;
            if (held_cnt_next >= 2'd2)
            begin
                res_next[n[1:0]] = usd_pkg::make_char({13'd0, held_next[1]}, usd_pkg::LEN_1,
                                                      1'b0, held_next[1]);
                n = n + 3'd1;
            end
            if (held_cnt_next == 2'd3)
            begin
                res_next[n[1:0]] = usd_pkg::make_char({13'd0, held_next[2]}, usd_pkg::LEN_1,
                                                      1'b0, held_next[2]);
                n = n + 3'd1;
            end
            held_cnt_next = '0;
            exp_len_next  = '0;
        end

        if (pending && is_cont)
        begin
            if (({1'b0, held_cnt_next} + 3'd1) >= exp_len_next)
            begin
                // Sequence complete: assemble the code point
                case (exp_len_next)
                    usd_pkg::LEN_2:
                        cp = {10'd0, held_next[0][4:0], b[5:0]};
                    usd_pkg::LEN_3:
                        cp = {5'd0, held_next[0][3:0], held_next[1][5:0], b[5:0]};
                    default:
                        cp = {held_next[0][2:0], held_next[1][5:0], held_next[2][5:0], b[5:0]};
                endcase
                res_next[n[1:0]] = usd_pkg::make_char(cp, exp_len_next, 1'b0, held_next[0]);
                n = n + 3'd1;
                held_cnt_next = '0;
                exp_len_next  = '0;
            end
            else
            begin
                // Hold the continuation and wait for more
                held_next[held_cnt_next] = b;
                held_cnt_next = held_cnt_next + 2'd1;
            end
        end
        else
        begin
            // Fresh byte
            if (len == usd_pkg::LEN_1)
            begin
                res_next[n[1:0]] = usd_pkg::make_char({13'd0, b}, usd_pkg::LEN_1, 1'b0, b);
                n = n + 3'd1;
            end
            else if (len == usd_pkg::LEN_BAD)
            begin
                res_next[n[1:0]] = usd_pkg::make_char('0, usd_pkg::LEN_BAD, 1'b1, b);
                n = n + 3'd1;
            end
            else
            begin
                held_next[0]  = b;
                held_cnt_next = 2'd1;
                exp_len_next  = len;
            end
        end

        // End of text with a sequence still open: flush it as invalid
        if (in_eot_reg && (held_cnt_next != '0) && (exp_len_next != '0))
        begin
            res_next[n[1:0]] = usd_pkg::make_char('0, usd_pkg::LEN_BAD, 1'b1, held_next[0]);
            n = n + 3'd1;
            if (held_cnt_next >= 2'd2)
            begin
                res_next[n[1:0]] = usd_pkg::make_char({13'd0, held_next[1]}, usd_pkg::LEN_1,
                                                      1'b0, held_next[1]);
                n = n + 3'd1;
            end
            if (held_cnt_next == 2'd3)
            begin
                res_next[n[1:0]] = usd_pkg::make_char({13'd0, held_next[2]}, usd_pkg::LEN_1,
                                                      1'b0, held_next[2]);
                n = n + 3'd1;
            end
            held_cnt_next = '0;
            exp_len_next  = '0;
        end

        res_cnt_next = n;
    end

    // Pending state advances only when a byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= '0;
            exp_len_reg  <= '0;
        end
        else if (advance)
        begin
            held_cnt_reg <= held_cnt_next;
            exp_len_reg  <= exp_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < usd_pkg::HELD_D; i++)
            begin
                held_reg[i] <= held_next[i];
            end
            for (int i = 0; i < usd_pkg::MAX_RES; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    // Result buffer control: load on advance, else drain on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            rd_idx_reg <= '0;
        end
        else if (advance)
        begin
            left_reg   <= res_cnt_next;
            rd_idx_reg <= '0;
        end
        else if (out_fire)
        begin
            left_reg   <= left_reg - 3'd1;
            rd_idx_reg <= rd_idx_reg + 2'd1;
        end
    end

    assign chars.valid       = (left_reg != '0);
    assign chars.code_point  = res_reg[rd_idx_reg].code_point;
    assign chars.seq_length  = res_reg[rd_idx_reg].seq_length;
    assign chars.invalid     = res_reg[rd_idx_reg].invalid;
    assign chars.raw_lead    = res_reg[rd_idx_reg].raw_lead;
    // The final buffered character is the last one caused by its byte
    assign chars.last_of_run = (left_reg == usd_pkg::LEN_1);

`ifndef ASSERT_OFF
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= usd_pkg::LEN_4)
        else $error("result buffer count out of range");

    a_read_window: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != '0) |-> (({2'b00, rd_idx_reg} + {1'b0, left_reg}) <= 4'd4))
        else $error("read index runs past loaded results");

    a_pending_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (held_cnt_reg == '0) == (exp_len_reg == '0))
        else $error("held count and expected length disagree");

    a_pending_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (held_cnt_reg != '0) |-> ((exp_len_reg >= usd_pkg::LEN_2) &&
                                  ({1'b0, held_cnt_reg} < exp_len_reg)))
        else $error("pending sequence holds too many bytes");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (rd_idx_reg == '0))
        else $error("result buffer load did not restart read index");
`endif

endmodule
